/* rtl/asmp_pkg.sv */
// Package for the ASCII signed modulo parser: field widths, character codes,
// result status codes and the command and status structures between modules.
// Depends on nothing.
`timescale 1ns / 1ps

package asmp_pkg;

    localparam int TOKEN_LENGTH = 10;

    localparam int CHAR_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int VAL_W       = 28;
    localparam int FIELDS_W    = STATUS_W + 3 * VAL_W;
    localparam int OUT_TDATA_W = ((FIELDS_W + 7) / 8) * 8;
    localparam int PAD_W       = OUT_TDATA_W - FIELDS_W;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Q = 8'h51;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Q = 8'h71;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_DIVZERO = 3'd1,
        ST_BIG1    = 3'd2,
        ST_BIG2    = 3'd3,
        ST_QUIT    = 3'd4
    } status_t;

    typedef struct packed {
        logic    add_first;
        logic    add_second;
        logic    set_first_neg;
        logic    set_second_neg;
        logic    clear_count;
        logic    clear_numbers;
        logic    div_start;
        logic    out_load;
        status_t out_code;
    } cmd_t;

    typedef struct packed {
        logic is_digit;
        logic is_minus;
        logic is_quit;
        logic count_trip;
        logic div_last;
        logic second_zero;
        logic out_free;
    } sts_t;

    // Bits needed to hold the largest number of the given digit count.
    function automatic int mag_width(input int digits);
        longint unsigned v;
        int w;
        v = 64'd1;
        w = 0;
        for (int i = 0; i < digits; i++)
        begin
            v = v * 64'd10;
        end
        v = v - 64'd1;
        while (v != 64'd0)
        begin
            w = w + 1;
            v = v >> 1;
        end
        return (w < 1) ? 1 : w;
    endfunction

endpackage

/* rtl/asmp_dp.sv */
// Datapath of the ASCII signed modulo parser: character decode, number
// registers, bit-serial restoring divider and the output word register.
// Depends on asmp_pkg.
`timescale 1ns / 1ps

module asmp_dp #(
    parameter int TOKEN_LENGTH = asmp_pkg::TOKEN_LENGTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [asmp_pkg::CHAR_W-1:0]         char_code,
    input  asmp_pkg::cmd_t                      cmd,
    output asmp_pkg::sts_t                      sts,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [asmp_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int MAG_W  = asmp_pkg::mag_width(TOKEN_LENGTH - 2);
    localparam int CNT_W  = $clog2(TOKEN_LENGTH - 1);
    localparam int DCNT_W = $clog2(MAG_W + 1);
    localparam int VAL_W  = asmp_pkg::VAL_W;
    localparam int EXT_W  = (MAG_W > VAL_W) ? MAG_W : VAL_W;

    logic [MAG_W-1:0]  first_mag_reg, first_mag_next;
    logic              first_neg_reg, first_neg_next;
    logic [MAG_W-1:0]  second_mag_reg, second_mag_next;
    logic              second_neg_reg, second_neg_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [MAG_W-1:0]  div_a_reg, div_a_next;
    logic [MAG_W:0]    rem_reg, rem_next;
    logic [DCNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [asmp_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [3:0]        digit;
    logic [MAG_W-1:0]  first_times_ten;
    logic [MAG_W-1:0]  second_times_ten;
    logic [MAG_W:0]    rem_shift;
    logic [MAG_W:0]    rem_diff;
    logic [EXT_W-1:0]  first_ext, second_ext, rem_ext;
    logic [VAL_W-1:0]  first_low, second_low, rem_low;
    logic [VAL_W-1:0]  a_val, b_val, r_val;
    logic [VAL_W-1:0]  a_sel, b_sel, r_sel;

    assign digit = char_code[3:0];

    assign sts.is_digit    = (char_code >= asmp_pkg::CHAR_ZERO) &&
                             (char_code <= asmp_pkg::CHAR_NINE);
    assign sts.is_minus    = (char_code == asmp_pkg::CHAR_MINUS);
    assign sts.is_quit     = (char_code == asmp_pkg::CHAR_UPPER_Q) ||
                             (char_code == asmp_pkg::CHAR_LOWER_Q);
    assign sts.count_trip  = (count_reg == CNT_W'(TOKEN_LENGTH - 2));
    assign sts.div_last    = (div_cnt_reg == DCNT_W'(1));
    assign sts.second_zero = (second_mag_reg == '0);
    assign sts.out_free    = !out_valid_reg || m_tready;

    assign first_times_ten  = (first_mag_reg << 3) + (first_mag_reg << 1) + MAG_W'(digit);
    assign second_times_ten = (second_mag_reg << 3) + (second_mag_reg << 1) + MAG_W'(digit);

    assign rem_shift = {rem_reg[MAG_W-1:0], div_a_reg[MAG_W-1]};
    assign rem_diff  = rem_shift - {1'b0, second_mag_reg};

    assign first_ext  = EXT_W'(first_mag_reg);
    assign second_ext = EXT_W'(second_mag_reg);
    assign rem_ext    = EXT_W'(rem_reg[MAG_W-1:0]);
    assign first_low  = first_ext[VAL_W-1:0];
    assign second_low = second_ext[VAL_W-1:0];
    assign rem_low    = rem_ext[VAL_W-1:0];
    assign a_val = first_neg_reg  ? (~first_low + VAL_W'(1))  : first_low;
    assign b_val = second_neg_reg ? (~second_low + VAL_W'(1)) : second_low;
    assign r_val = first_neg_reg  ? (~rem_low + VAL_W'(1))    : rem_low;

    always_comb
    begin
        first_mag_next  = first_mag_reg;
        first_neg_next  = first_neg_reg;
        second_mag_next = second_mag_reg;
        second_neg_next = second_neg_reg;
        count_next      = count_reg;
        div_a_next      = div_a_reg;
        rem_next        = rem_reg;
        div_cnt_next    = div_cnt_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;

        if (cmd.add_first)
        begin
            first_mag_next = first_times_ten;
        end
        if (cmd.add_second)
        begin
            second_mag_next = second_times_ten;
        end
        if (cmd.set_first_neg)
        begin
            first_neg_next = 1'b1;
        end
        if (cmd.set_second_neg)
        begin
            second_neg_next = 1'b1;
        end
        if (cmd.clear_count)
        begin
            count_next = (cmd.add_first || cmd.add_second) ? CNT_W'(1) : '0;
        end
        else if (cmd.add_first || cmd.add_second)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.clear_numbers)
        begin
            first_mag_next  = '0;
            first_neg_next  = 1'b0;
            second_mag_next = '0;
            second_neg_next = 1'b0;
            count_next      = '0;
        end

        if (cmd.div_start)
        begin
            div_a_next   = first_mag_reg;
            rem_next     = '0;
            div_cnt_next = DCNT_W'(MAG_W);
        end
        else if (div_cnt_reg != '0)
        begin
            div_a_next   = {div_a_reg[MAG_W-2:0], 1'b0};
            rem_next     = rem_diff[MAG_W] ? rem_shift : rem_diff;
            div_cnt_next = div_cnt_reg - DCNT_W'(1);
        end

        case (cmd.out_code)
            asmp_pkg::ST_OK:
            begin
                a_sel = a_val;
                b_sel = b_val;
                r_sel = r_val;
            end
            asmp_pkg::ST_DIVZERO:
            begin
                a_sel = a_val;
                b_sel = b_val;
                r_sel = '0;
            end
            default:
            begin
                a_sel = '0;
                b_sel = '0;
                r_sel = '0;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {{asmp_pkg::PAD_W{1'b0}}, r_sel, b_sel, a_sel, cmd.out_code};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_mag_reg  <= '0;
            first_neg_reg  <= 1'b0;
            second_mag_reg <= '0;
            second_neg_reg <= 1'b0;
            count_reg      <= '0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            first_mag_reg  <= first_mag_next;
            first_neg_reg  <= first_neg_next;
            second_mag_reg <= second_mag_next;
            second_neg_reg <= second_neg_next;
            count_reg      <= count_next;
            div_cnt_reg    <= div_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_a_reg    <= div_a_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* rtl/asmp_ctrl.sv */
// Controller of the ASCII signed modulo parser: the expression state machine
// that issues datapath commands and drives the input ready.
// Depends on asmp_pkg.
`timescale 1ns / 1ps

module asmp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  asmp_pkg::sts_t sts,
    output asmp_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_START,
        S_FIRST,
        S_SKIP,
        S_SECOND,
        S_DIV,
        S_RESULT,
        S_ERROR,
        S_HALT
    } ctrl_state_t;

    ctrl_state_t       state_reg, state_next;
    asmp_pkg::status_t err_code_reg, err_code_next;
    logic              ready_reg, ready_next;
    logic              accept;

    assign accept = s_tvalid && ready_reg;

    always_comb
    begin
        state_next    = state_reg;
        err_code_next = err_code_reg;
        cmd           = '0;
        cmd.out_code  = asmp_pkg::ST_OK;

        case (state_reg)
            S_START:
            begin
                if (accept)
                begin
                    if (sts.is_quit)
                    begin
                        err_code_next = asmp_pkg::ST_QUIT;
                        state_next    = S_ERROR;
                    end
                    else if (sts.is_minus)
                    begin
                        cmd.set_first_neg = 1'b1;
                        state_next        = S_FIRST;
                    end
                    else if (sts.is_digit)
                    begin
                        if (sts.count_trip)
                        begin
                            err_code_next = asmp_pkg::ST_BIG1;
                            state_next    = S_ERROR;
                        end
                        else
                        begin
                            cmd.add_first = 1'b1;
                            state_next    = S_FIRST;
                        end
                    end
                    else
                    begin
                        state_next = S_SKIP;
                    end
                end
            end
            S_FIRST:
            begin
                if (accept)
                begin
                    if (sts.is_digit)
                    begin
                        if (sts.count_trip)
                        begin
                            err_code_next = asmp_pkg::ST_BIG1;
                            state_next    = S_ERROR;
                        end
                        else
                        begin
                            cmd.add_first = 1'b1;
                        end
                    end
                    else if (sts.is_minus)
                    begin
                        cmd.set_second_neg = 1'b1;
                        cmd.clear_count    = 1'b1;
                        state_next         = S_SECOND;
                    end
                    else
                    begin
                        state_next = S_SKIP;
                    end
                end
            end
            S_SKIP:
            begin
                if (accept)
                begin
                    if (sts.is_digit)
                    begin
                        cmd.add_second  = 1'b1;
                        cmd.clear_count = 1'b1;
                        state_next      = S_SECOND;
                    end
                    else if (sts.is_minus)
                    begin
                        cmd.set_second_neg = 1'b1;
                        cmd.clear_count    = 1'b1;
                        state_next         = S_SECOND;
                    end
                end
            end
            S_SECOND:
            begin
                if (accept)
                begin
                    if (sts.is_digit)
                    begin
                        if (sts.count_trip)
                        begin
                            err_code_next = asmp_pkg::ST_BIG2;
                            state_next    = S_ERROR;
                        end
                        else
                        begin
                            cmd.add_second = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load      = 1'b1;
                    cmd.out_code      = sts.second_zero ? asmp_pkg::ST_DIVZERO
                                                        : asmp_pkg::ST_OK;
                    cmd.clear_numbers = 1'b1;
                    state_next        = S_START;
                end
            end
            S_ERROR:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_code = err_code_reg;
                    state_next   = S_HALT;
                end
            end
            S_HALT:
            begin
                state_next = S_HALT;
            end
            default:
            begin
                state_next = S_HALT;
            end
        endcase

        ready_next = !((state_next == S_DIV) || (state_next == S_RESULT) ||
                       (state_next == S_ERROR));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_START;
            err_code_reg <= asmp_pkg::ST_OK;
            ready_reg    <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            err_code_reg <= err_code_next;
            ready_reg    <= ready_next;
        end
    end

    assign s_tready = ready_reg;

    a_load_when_free : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("Output word loaded while the previous one is still held.");

    a_no_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV || state_reg == S_RESULT || state_reg == S_ERROR) |-> !ready_reg)
        else $error("Input ready while a result is being formed.");

    a_div_start_src : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (state_reg == S_SECOND && accept && !sts.is_digit))
        else $error("Divider started outside the end of the divisor.");

    a_div_follows : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (state_reg == S_DIV))
        else $error("Controller did not wait for the divider.");

endmodule

/* rtl/ascii_signed_modulo_parser_core.sv */
// Top level of the ASCII signed modulo parser: joins the controller and the
// datapath. Depends on asmp_pkg, asmp_ctrl and asmp_dp.
`timescale 1ns / 1ps
//
// Channel   Direction  Width  Word contents
// s_*       in         8      char_code
// m_*       out        88     status, dividend, divisor, remainder
//
// An ordinary character leaves input ready high, and a new one is accepted
// in the next cycle. The character that ends the divisor starts the
// restoring divider, one quotient bit a cycle, so input ready stays low
// while it works through the magnitude width (27 bits by default). Reset
// clears all control state and returns to the start of an expression. A
// held output word does not stop ordinary characters; a new result waits
// in the controller, input ready low, until the output register frees.

module ascii_signed_modulo_parser_core #(
    parameter int TOKEN_LENGTH = asmp_pkg::TOKEN_LENGTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // Fields from bit 0: char_code[7:0].
    input  logic [asmp_pkg::CHAR_W-1:0]      s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // Fields from bit 0: status[2:0], dividend[30:3], divisor[58:31],
    // remainder[86:59], zero pad bit 87.
    output logic [asmp_pkg::OUT_TDATA_W-1:0] m_tdata
);

    asmp_pkg::cmd_t cmd;
    asmp_pkg::sts_t sts;

    asmp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    asmp_dp #(
        .TOKEN_LENGTH (TOKEN_LENGTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_code (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
